### rtl/bodr_pkg.sv
`timescale 1ns / 1ps

package bodr_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_RED_LEVELS   = 2'd0,
    REG_GREEN_LEVELS = 2'd1,
    REG_BLUE_LEVELS  = 2'd2
  } bodr_reg_t;

  localparam int LEVELS_W = 9;
  localparam int PIX_W    = 8;
  localparam int COORD_W  = 16;
  localparam int STEP_W   = 9;   // step = 256 / (levels - 1), 1..256
  localparam int RECIP_W  = 17;  // ceil(2^16 / step)
  localparam int RECIP_SH = 16;
  localparam int LAT      = 5;   // register stages from accept to result

  // Per-channel coefficients for one pixel
  typedef struct packed {
    logic [STEP_W-1:0]  step;
    logic [RECIP_W-1:0] recip;
    logic [PIX_W-1:0]   thr;    // threshold index scaled to 0..255
  } bodr_coef_t;

endpackage

### rtl/bayer_ordered_dither_rgb_top.sv
`timescale 1ns / 1ps

// Bayer ordered dither for RGB pixels, 8 bits a channel. Each channel is
// quantised to its own level count (registers 0..2: red, green, blue levels,
// 2..256, reset 2; values below 2 act as 2, above 256 as 256). The threshold
// matrix size follows from the level count and is indexed by the low four
// bits of pixel_row and pixel_column. A pixel is taken on any clock edge with
// start high; busy never rises, so one pixel a clock is sustained. Each result
// passes the five-stage datapath (reciprocal multiply, remainder, rounding
// compare, rescale multiply) and appears for one cycle with done high, in
// input order. The receiver cannot stall: the result must be taken in that
// cycle. Level registers may be written only while no pixel is in flight;
// cfg_ready is always high.

module bayer_ordered_dither_rgb_top
  import bodr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // pixel input
  input  logic                start,
  output logic                busy,
  input  logic [PIX_W-1:0]    red_in,
  input  logic [PIX_W-1:0]    green_in,
  input  logic [PIX_W-1:0]    blue_in,
  input  logic [COORD_W-1:0]  pixel_row,
  input  logic [COORD_W-1:0]  pixel_column,
  // result
  output logic                done,
  output logic [PIX_W-1:0]    red_out,
  output logic [PIX_W-1:0]    green_out,
  output logic [PIX_W-1:0]    blue_out,
  // configuration write
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [LEVELS_W-1:0] cfg_data
);

  logic [LEVELS_W-1:0] red_levels;
  logic [LEVELS_W-1:0] green_levels;
  logic [LEVELS_W-1:0] blue_levels;
  logic [LAT-1:0]      vld;
  logic                accept;

  bodr_coef_t red_coef;
  bodr_coef_t green_coef;
  bodr_coef_t blue_coef;

  // Fully pipelined, never back-pressures
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign done      = vld[LAT-1];

  // Level registers; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      red_levels   <= LEVELS_W'(2);
      green_levels <= LEVELS_W'(2);
      blue_levels  <= LEVELS_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RED_LEVELS:   red_levels   <= cfg_data;
        REG_GREEN_LEVELS: green_levels <= cfg_data;
        REG_BLUE_LEVELS:  blue_levels  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid bits travel alongside the channel datapaths
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], accept};
    end
  end

  bodr_prep u_prep_red (
    .levels (red_levels),
    .row    (pixel_row[3:0]),
    .col    (pixel_column[3:0]),
    .coef   (red_coef)
  );

  bodr_prep u_prep_green (
    .levels (green_levels),
    .row    (pixel_row[3:0]),
    .col    (pixel_column[3:0]),
    .coef   (green_coef)
  );

  bodr_prep u_prep_blue (
    .levels (blue_levels),
    .row    (pixel_row[3:0]),
    .col    (pixel_column[3:0]),
    .coef   (blue_coef)
  );

  bodr_chan u_chan_red (
    .clk  (clk),
    .c_in (red_in),
    .coef (red_coef),
    .res  (red_out)
  );

  bodr_chan u_chan_green (
    .clk  (clk),
    .c_in (green_in),
    .coef (green_coef),
    .res  (green_out)
  );

  bodr_chan u_chan_blue (
    .clk  (clk),
    .c_in (blue_in),
    .coef (blue_coef),
    .res  (blue_out)
  );

endmodule

### rtl/bodr_prep.sv
`timescale 1ns / 1ps

module bodr_prep
  import bodr_pkg::*;
(
  input  logic [LEVELS_W-1:0] levels,
  input  logic [3:0]          row,
  input  logic [3:0]          col,
  output bodr_coef_t          coef
);

  logic [STEP_W-1:0]  step_tab  [256];
  logic [RECIP_W-1:0] recip_tab [256];
  logic [2:0]         mbits_tab [256];

  // Tables indexed by levels - 1; entry 0 is never selected
  for (genvar i = 0; i < 256; i++) begin : g_tab
    localparam int Div   = (i < 1) ? 1 : i;
    localparam int Step  = 256 / Div;
    localparam int Recip = (65536 + Step - 1) / Step;
    localparam int Vq    = 256 / (i + 1);
    localparam int Ex    = $clog2(Vq);
    localparam int Mb    = (Ex + 1) / 2;
    assign step_tab[i]  = STEP_W'(Step);
    assign recip_tab[i] = RECIP_W'(Recip);
    assign mbits_tab[i] = 3'(Mb);
  end

  logic [7:0] idx;
  logic [2:0] mbits;
  logic [3:0] p;
  logic [7:0] thr;

  always_comb begin
    priority if (levels < LEVELS_W'(2)) begin
      idx = 8'd1;
    end else if (levels > LEVELS_W'(256)) begin
      idx = 8'd255;
    end else begin
      idx = 8'(levels - LEVELS_W'(1));
    end
  end

  assign mbits = mbits_tab[idx];
  assign p     = row ^ col;

  // Bit-reversed interleave placed at the top of an 8-bit field
  always_comb begin
    thr = '0;
    for (int t = 0; t < 4; t++) begin
      if (3'(t) < mbits) begin
        thr[7-2*t] = p[t];
        thr[6-2*t] = row[t];
      end
    end
  end

  assign coef.step  = step_tab[idx];
  assign coef.recip = recip_tab[idx];
  assign coef.thr   = thr;

endmodule

### rtl/bodr_chan.sv
`timescale 1ns / 1ps

module bodr_chan
  import bodr_pkg::*;
(
  input  logic             clk,
  input  logic [PIX_W-1:0] c_in,
  input  bodr_coef_t       coef,
  output logic [PIX_W-1:0] res
);

  // stage 1
  logic [PIX_W-1:0] s1_c;
  bodr_coef_t       s1_coef;
  // stage 2
  logic [PIX_W-1:0]  s2_c;
  logic [PIX_W-1:0]  s2_a;
  logic [16:0]       s2_st;
  logic [STEP_W-1:0] s2_step;
  // stage 3
  logic [PIX_W-1:0]  s3_a;
  logic [PIX_W-1:0]  s3_r;
  logic [16:0]       s3_st;
  logic [STEP_W-1:0] s3_step;
  logic              s3_pos;
  // stage 4
  logic [8:0]        s4_q;
  logic [STEP_W-1:0] s4_step;
  logic              s4_pos;

  logic [24:0] quo_prod;
  logic [16:0] ast;
  logic [17:0] pos_lhs;
  logic [17:0] pos_rhs;
  logic [17:0] rnd_lhs;
  logic [17:0] rnd_rhs;
  logic [17:0] out_prod;

  // quotient c / step by reciprocal; exact for 8-bit c
  assign quo_prod = 25'(s1_c) * 25'(s1_coef.recip);
  assign ast      = 17'(s2_a) * 17'(s2_step);
  // numerator positive: 256c + step*thr > 128*step
  assign pos_lhs  = {2'b00, s2_c, 8'h00} + 18'(s2_st);
  assign pos_rhs  = {2'b00, s2_step, 7'h00};
  // round up when 256r + step*thr reaches 256*step
  assign rnd_lhs  = {2'b00, s3_r, 8'h00} + 18'(s3_st);
  assign rnd_rhs  = {1'b0, s3_step, 8'h00};
  assign out_prod = 18'(s4_q) * 18'(s4_step);

  always_ff @(posedge clk) begin
    s1_c    <= c_in;
    s1_coef <= coef;

    s2_c    <= s1_c;
    s2_a    <= quo_prod[RECIP_SH+PIX_W-1:RECIP_SH];
    s2_st   <= 17'(s1_coef.step) * 17'(s1_coef.thr);
    s2_step <= s1_coef.step;

    s3_a    <= s2_a;
    s3_r    <= 8'(17'(s2_c) - ast);
    s3_st   <= s2_st;
    s3_step <= s2_step;
    s3_pos  <= (pos_lhs > pos_rhs);

    s4_q    <= 9'(s3_a) + 9'(rnd_lhs >= rnd_rhs);
    s4_step <= s3_step;
    s4_pos  <= s3_pos;

    if (!s4_pos) begin
      res <= '0;
    end else if (out_prod > 18'd255) begin
      res <= 8'hFF;
    end else begin
      res <= out_prod[PIX_W-1:0];
    end
  end

endmodule

### rtl/bodr_chk.sv
`timescale 1ns / 1ps

module bodr_chk
  import bodr_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // every transfer yields a result after the pipeline latency
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("transfer without result");

  // no result without a matching transfer
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without transfer");

  // reset flushes the pipeline
  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result right after reset");

endmodule

bind bayer_ordered_dither_rgb_top bodr_chk u_chk (.*);

### tb/bayer_ordered_dither_rgb_top_tb.sv
`timescale 1ns / 1ps

module bayer_ordered_dither_rgb_top_tb;
  import bodr_pkg::*;

  // Index 3 maps to no register. A write to it must leave all levels alone.
  localparam logic [1:0] REG_UNUSED = 2'd3;
  // Cycles with no transfer of any kind before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_PIXELS = 110;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_pixel_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [PIX_W-1:0]    red_in = '0;
  logic [PIX_W-1:0]    green_in = '0;
  logic [PIX_W-1:0]    blue_in = '0;
  logic [COORD_W-1:0]  pixel_row = '0;
  logic [COORD_W-1:0]  pixel_column = '0;
  logic                done;
  logic [PIX_W-1:0]    red_out;
  logic [PIX_W-1:0]    green_out;
  logic [PIX_W-1:0]    blue_out;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = '0;
  logic [LEVELS_W-1:0] cfg_data = '0;

  // Shadow copies of the level registers, raw as written (clamping happens
  // in the predictor, as in the block).
  logic [LEVELS_W-1:0] red_lv = 9'd2;
  logic [LEVELS_W-1:0] green_lv = 9'd2;
  logic [LEVELS_W-1:0] blue_lv = 9'd2;

  // Dithered pixels still owed by the block, oldest first
  rgb_pixel_t pending_pixels [$];
  int mismatch_count = 0;
  int quiet_cycles = 0;

  // Level counts worth hitting often: out-of-range, matrix size boundaries
  // (n changes past 256/L = 1, 4, 16, 64) and the single-element matrix.
  int level_edges [16] = '{0, 1, 2, 3, 4, 5, 8, 9, 16, 17, 128, 129, 255, 256, 257, 511};

  bayer_ordered_dither_rgb_top DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .red_in       (red_in),
    .green_in     (green_in),
    .blue_in      (blue_in),
    .pixel_row    (pixel_row),
    .pixel_column (pixel_column),
    .done         (done),
    .red_out      (red_out),
    .green_out    (green_out),
    .blue_out     (blue_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Predicted channel value. Exact integer form of
  //   round(c/step + k/n^2 - 1/2) * step, half away from zero, clamped.
  function automatic logic [PIX_W-1:0] dithered_level(input logic [PIX_W-1:0] c,
                                                      input logic [LEVELS_W-1:0] lv_reg,
                                                      input logic [3:0] row,
                                                      input logic [3:0] col);
    int lv;
    int step;
    int span;
    int e;
    int m;
    int scale;
    logic [3:0] p;
    logic [7:0] lace;
    logic [7:0] k;
    longint num;
    longint den;
    longint q;
    if (lv_reg < 2) lv = 2;
    else if (lv_reg > 256) lv = 256;
    else lv = lv_reg;
    step = 256 / (lv - 1);
    // matrix is 2^m square, m = ceil(ceil(log2(256/L)) / 2)
    span = 256 / lv;
    e = 0;
    while (e < 8 && (1 << e) < span) e++;
    m = (e + 1) / 2;
    // interleave: row^col on even bits, row on odd bits, then bit-reverse
    p = row ^ col;
    lace = '0;
    k = '0;
    for (int t = 0; t < m; t++) begin
      lace[2*t]   = p[t];
      lace[2*t+1] = row[t];
    end
    for (int s = 0; s < 2*m; s++) k[2*m-1-s] = lace[s];
    scale = 256 >> (2*m);
    num = 256 * longint'(c) + longint'(step) * (longint'(k) * scale - 128);
    den = 256 * longint'(step);
    if (num <= 0) return '0;
    q = (2*num + den) / (2*den);
    if (q * step > 255) return 8'd255;
    return PIX_W'(q * step);
  endfunction

  function automatic logic [LEVELS_W-1:0] pick_level();
    case ($urandom_range(0, 3))
      0: return LEVELS_W'(level_edges[$urandom_range(0, 15)]);
      1: return LEVELS_W'($urandom_range(0, 511));
      default: return LEVELS_W'($urandom_range(2, 256));
    endcase
  endfunction

  // One pixel transfer; start stays high afterwards so back-to-back pixels
  // never see start dropped and raised in the same step.
  task automatic send_pixel(input logic [PIX_W-1:0] r, g, b,
                            input logic [COORD_W-1:0] row, col);
    start        <= 1'b1;
    red_in       <= r;
    green_in     <= g;
    blue_in      <= b;
    pixel_row    <= row;
    pixel_column <= col;
    do @(posedge clk); while (busy);
    pending_pixels.push_back('{dithered_level(r, red_lv, row[3:0], col[3:0]),
                               dithered_level(g, green_lv, row[3:0], col[3:0]),
                               dithered_level(b, blue_lv, row[3:0], col[3:0])});
  endtask

  task automatic idle_gap(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Every pixel gives a result, so an empty queue means the pipe is empty;
  // the extra wait after that covers the done register itself.
  task automatic wait_for_results();
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Writes all three levels back to back, optionally with a stray write to
  // the unused index; valid only drops after the last transfer.
  task automatic program_levels(input logic [LEVELS_W-1:0] r, g, b,
                                input bit poke_unused);
    logic [1:0]          idx [4];
    logic [LEVELS_W-1:0] val [4];
    int                  count;
    idx = '{REG_RED_LEVELS, REG_UNUSED, REG_GREEN_LEVELS, REG_BLUE_LEVELS};
    val = '{r, LEVELS_W'($urandom), g, b};
    for (int i = 0; i < 4; i++) begin
      if (idx[i] != REG_UNUSED || poke_unused) begin
        cfg_valid <= 1'b1;
        cfg_index <= idx[i];
        cfg_data  <= val[i];
        do @(posedge clk); while (!cfg_ready);
      end
    end
    cfg_valid <= 1'b0;
    red_lv   = r;
    green_lv = g;
    blue_lv  = b;
  endtask

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t mismatch: %s", $realtime, what);
  endtask

  task automatic compare_channel(input string name, input logic [PIX_W-1:0] want, got);
    if (got !== want) report_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
  endtask

  // Results checked mid-cycle so the check never races the edge-driven
  // stimulus; a result is valid for the whole cycle it is strobed.
  always @(negedge clk) begin : result_check
    rgb_pixel_t want;
    if (!rst && done) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d %0d %0d",
                                  red_out, green_out, blue_out));
      end else begin
        want = pending_pixels.pop_front();
        compare_channel("red_out", want.red, red_out);
        compare_channel("green_out", want.green, green_out);
        compare_channel("blue_out", want.blue, blue_out);
      end
    end
  end

  // Hang detector: any pixel, result or register transfer resets the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("bayer_ordered_dither_rgb_top_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Levels at reset are 2: full 16x16 matrix, step 256, so a bright pixel
  // with a high threshold rounds to 256 and must clamp to 255.
  task automatic test_reset_levels();
    send_pixel(8'd0, 8'd0, 8'd0, 16'h0000, 16'h0000);
    send_pixel(8'd255, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF);
    send_pixel(8'd128, 8'd127, 8'd64, 16'h0001, 16'h0002);
    send_pixel(8'd200, 8'd50, 8'd100, 16'hAAA5, 16'h555A);
  endtask

  // Out-of-range counts: 0 and 1 behave as 2, 511 as 256. Also a stray write
  // to the unused index, which must change nothing.
  task automatic test_level_clamping();
    wait_for_results();
    program_levels(9'd0, 9'd1, 9'd511, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 16'h000F, 16'h0000);
    send_pixel(8'd0, 8'd1, 8'd254, 16'h0003, 16'h000C);
    send_pixel(8'd127, 8'd128, 8'd129, 16'h1237, 16'hFED8);
    send_pixel(8'd64, 8'd192, 8'd1, 16'h8006, 16'h0009);
  endtask

  // 256 and 129 levels give a one-element matrix (threshold 0); 128 is the
  // first count with a 2x2 matrix. Zero input drives the sum to zero or below.
  task automatic test_single_element_matrix();
    wait_for_results();
    program_levels(9'd256, 9'd129, 9'd128, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 16'h0000, 16'h0001);
    send_pixel(8'd1, 8'd1, 8'd1, 16'h0001, 16'h0000);
    send_pixel(8'd255, 8'd255, 8'd255, 16'h0001, 16'h0001);
    send_pixel(8'd3, 8'd2, 8'd2, 16'hFFFE, 16'h7FFF);
  endtask

  // Coarse, middling and over-range counts side by side.
  task automatic test_mixed_levels();
    wait_for_results();
    program_levels(9'd3, 9'd17, 9'd257, 1'b0);
    send_pixel(8'd127, 8'd15, 8'd200, 16'h0005, 16'h000A);
    send_pixel(8'd128, 8'd16, 8'd255, 16'h000A, 16'h0005);
    send_pixel(8'd255, 8'd240, 8'd0, 16'h0C03, 16'h30F0);
    send_pixel(8'd0, 8'd255, 8'd77, 16'h5555, 16'hAAAA);
  endtask

  // Random levels per phase, random pixels and coordinates. Some phases run
  // with no gaps at all, and the last one always does.
  task automatic test_random_levels();
    bit gappy;
    logic [PIX_W-1:0] chan [3];
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_for_results();
      program_levels(pick_level(), pick_level(), pick_level(), phase % 4 == 2);
      gappy = (phase != RANDOM_PHASES - 1) && (phase % 3 != 1);
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        for (int c = 0; c < 3; c++) begin
          case ($urandom_range(0, 7))
            0: chan[c] = 8'd0;
            1: chan[c] = 8'd255;
            default: chan[c] = PIX_W'($urandom);
          endcase
        end
        if (gappy && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 4));
        send_pixel(chan[0], chan[1], chan[2], COORD_W'($urandom), COORD_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_levels();
    test_level_clamping();
    test_single_element_matrix();
    test_mixed_levels();
    test_random_levels();
    wait_for_results();
    // allow for any stray result trailing the last one expected
    repeat (LAT + 4) @(posedge clk);
    if (mismatch_count == 0 && pending_pixels.size() == 0) begin
      $display("bayer_ordered_dither_rgb_top_tb: clean");
    end else begin
      $display("bayer_ordered_dither_rgb_top_tb: errors");
    end
    $finish;
  end

endmodule
